// ----- hw/rtl/differential_drive_odometry_macros.svh -----
// Assertion macros shared by the odometry RTL.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_MACROS_SVH
`ifndef ASSERT_OFF
`define DDO_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("odometry assertion failed");
`define DDO_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("odometry assertion failed");
`else
`define DDO_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define DDO_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- hw/rtl/ddo_pkg.sv -----
// Shared types, constants and tables of the odometry block.
`default_nettype none
package ddo_pkg;

    localparam int COUNT_BITS_DEFAULT   = 16;
    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int QUEUE_DEPTH          = 2;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 28;
    localparam int DIST_BITS      = 24;
    localparam int TURN_BITS_CFG  = 28;

    localparam logic [DIST_BITS-1:0]     DISTANCE_RESET = 24'd21082;
    localparam logic [TURN_BITS_CFG-1:0] TURN_RESET     = 28'd1753047;

    localparam int US_BITS    = 20;
    localparam int TRIG_BITS  = 34;
    localparam int ANGLE_BITS = 33;
    localparam int ACC_BITS   = 71;
    localparam int LIN_SHIFT  = 9;
    localparam int ANG_SHIFT  = 16;

    localparam logic signed [TRIG_BITS-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DISTANCE = 1'b0,
        CFG_TURN     = 1'b1
    } ddo_cfg_index_t;

    typedef struct packed {
        logic [DIST_BITS-1:0]     distance_per_count;
        logic [TURN_BITS_CFG-1:0] turn_per_count_difference;
    } ddo_cfg_t;

    typedef struct packed {
        logic idle;
        logic load;
    } ddo_back_status_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ddo_if.sv -----
// Valid/ready channel interfaces for encoder samples and pose results.
`default_nettype none
interface ddo_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] left_count;
    logic [15:0] right_count;
    logic [19:0] elapsed_us;

    modport source (output valid, output left_count, output right_count,
                    output elapsed_us, input ready);
    modport sink (input valid, input left_count, input right_count,
                  input elapsed_us, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic               time_zero;

    modport source (output valid, output pos_x, output pos_y, output heading,
                    output linear_velocity, output angular_velocity,
                    output time_zero, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading,
                  input linear_velocity, input angular_velocity,
                  input time_zero, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ddo_front.sv -----
// Front end: count deltas, travel and heading change scaling.
`default_nettype none
module ddo_front #(
    parameter int COUNT_BITS = ddo_pkg::COUNT_BITS_DEFAULT,
    localparam int TRAVEL_BITS = COUNT_BITS + 26,
    localparam int TURN_BITS = COUNT_BITS + 30,
    localparam int WORD_BITS = TRAVEL_BITS + TURN_BITS + ddo_pkg::US_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ddo_in_if.sink                     in_word,
    input  wire ddo_pkg::ddo_cfg_t     cfg,
    output logic                       push_valid,
    input  wire logic                  push_ready,
    output logic [WORD_BITS-1:0]       push_data
);
    import ddo_pkg::*;

    logic [COUNT_BITS-1:0]        prev_left_reg;
    logic [COUNT_BITS-1:0]        prev_right_reg;
    logic                         s1_valid_reg;
    logic signed [COUNT_BITS:0]   sum_reg;
    logic signed [COUNT_BITS:0]   diff_reg;
    logic [US_BITS-1:0]           us1_reg;
    logic                         s2_valid_reg;
    logic signed [TRAVEL_BITS-1:0] travel_reg;
    logic signed [TURN_BITS-1:0]  dth_reg;
    logic [US_BITS-1:0]           us2_reg;

    logic [COUNT_BITS-1:0]        cur_left;
    logic [COUNT_BITS-1:0]        cur_right;
    logic signed [COUNT_BITS-1:0] dl;
    logic signed [COUNT_BITS-1:0] dr;
    logic signed [COUNT_BITS:0]   dl_ext;
    logic signed [COUNT_BITS:0]   dr_ext;
    logic signed [DIST_BITS:0]    dist_s;
    logic signed [TURN_BITS_CFG:0] turn_s;
    logic signed [TRAVEL_BITS-1:0] travel_next;
    logic signed [TURN_BITS-1:0]  dth_next;
    logic                         adv2;
    logic                         accept;

    assign cur_left  = COUNT_BITS'(in_word.left_count);
    assign cur_right = COUNT_BITS'(in_word.right_count);
    assign dl        = $signed(cur_left - prev_left_reg);
    assign dr        = $signed(cur_right - prev_right_reg);
    assign dl_ext    = dl;
    assign dr_ext    = dr;
    assign dist_s    = $signed({1'b0, cfg.distance_per_count});
    assign turn_s    = $signed({1'b0, cfg.turn_per_count_difference});
    assign travel_next = sum_reg * dist_s;
    assign dth_next    = diff_reg * turn_s;

    assign adv2          = s1_valid_reg && (!s2_valid_reg || push_ready);
    assign in_word.ready = !s1_valid_reg || adv2;
    assign accept        = in_word.valid && in_word.ready;
    assign push_valid    = s2_valid_reg;
    assign push_data     = {travel_reg, dth_reg, us2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            sum_reg        <= '0;
            diff_reg       <= '0;
            us1_reg        <= '0;
            travel_reg     <= '0;
            dth_reg        <= '0;
            us2_reg        <= '0;
        end
        else
        begin
            if (accept)
            begin
                prev_left_reg  <= cur_left;
                prev_right_reg <= cur_right;
                sum_reg        <= dl_ext + dr_ext;
                diff_reg       <= dr_ext - dl_ext;
                us1_reg        <= in_word.elapsed_us;
                s1_valid_reg   <= 1'b1;
            end
            else if (adv2)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (adv2)
            begin
                travel_reg   <= travel_next;
                dth_reg      <= dth_next;
                us2_reg      <= us1_reg;
                s2_valid_reg <= 1'b1;
            end
            else if (push_ready)
            begin
                s2_valid_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ddo_queue.sv -----
// Short word queue between the front and back ends.
`default_nettype none
module ddo_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);
    import ddo_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_reg;
    logic [PW-1:0]    rd_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNTW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ddo_rate_div.sv -----
// Serial divider for velocity: value * 1e6 / (us * 2^SHIFT), saturated.
`default_nettype none
module ddo_rate_div #(
    parameter int NUM_BITS = 42,
    parameter int SHIFT = 9
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [NUM_BITS-1:0] num,
    input  wire logic [ddo_pkg::US_BITS-1:0] us,
    output logic                            done,
    output logic [31:0]                     result
);
    import ddo_pkg::*;

    localparam int DW = US_BITS + SHIFT;
    localparam int CW = ((63 > DW + 32) ? 63 : DW + 32) + 1;

    typedef enum logic [2:0] {D_IDLE, D_MUL, D_CHECK, D_RUN, D_DONE} div_state_t;

    div_state_t         state_reg;
    logic               neg_reg;
    logic               big_reg;
    logic               zero_reg;
    logic               ovf_reg;
    logic [42:0]        mag_reg;
    logic [US_BITS-1:0] us_reg;
    logic [62:0]        prod_reg;
    logic [CW-1:0]      rem_reg;
    logic [CW-1:0]      dsh_reg;
    logic [31:0]        q_reg;
    logic [4:0]         cnt_reg;

    logic [NUM_BITS-1:0] mag;
    logic [CW-1:0]       den;
    logic                fits;

    assign mag  = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
    assign den  = CW'({us_reg, SHIFT'(0)});
    assign fits = rem_reg >= dsh_reg;
    assign done = state_reg == D_DONE;

    always_comb
    begin
        if (zero_reg)
        begin
            result = '0;
        end
        else if (neg_reg)
        begin
            result = (ovf_reg || q_reg > 32'h8000_0000) ? 32'h8000_0000 : -q_reg;
        end
        else
        begin
            result = (ovf_reg || q_reg[31]) ? 32'h7FFF_FFFF : q_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            neg_reg   <= 1'b0;
            big_reg   <= 1'b0;
            zero_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            mag_reg   <= '0;
            us_reg    <= '0;
            prod_reg  <= '0;
            rem_reg   <= '0;
            dsh_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                D_IDLE, D_DONE:
                begin
                    if (start)
                    begin
                        neg_reg   <= num[NUM_BITS-1];
                        big_reg   <= (mag >> 43) != '0;
                        mag_reg   <= 43'(mag);
                        us_reg    <= us;
                        zero_reg  <= us == '0;
                        state_reg <= D_MUL;
                    end
                end
                D_MUL:
                begin
                    prod_reg  <= mag_reg * 20'd1000000;
                    state_reg <= D_CHECK;
                end
                D_CHECK:
                begin
                    ovf_reg   <= big_reg || (CW'(prod_reg) >= (den << 32));
                    rem_reg   <= CW'(prod_reg);
                    dsh_reg   <= den << 31;
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= D_RUN;
                end
                D_RUN:
                begin
                    if (fits)
                    begin
                        rem_reg <= rem_reg - dsh_reg;
                    end
                    q_reg   <= {q_reg[30:0], fits};
                    dsh_reg <= dsh_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= D_DONE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/ddo_back.sv -----
// Back end: CORDIC heading rotation, position projection, pose and output.
`default_nettype none
module ddo_back #(
    parameter int COUNT_BITS = ddo_pkg::COUNT_BITS_DEFAULT,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEFAULT,
    localparam int TRAVEL_BITS = COUNT_BITS + 26,
    localparam int TURN_BITS = COUNT_BITS + 30,
    localparam int WORD_BITS = TRAVEL_BITS + TURN_BITS + ddo_pkg::US_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pop_valid,
    output logic                       pop_ready,
    input  wire logic [WORD_BITS-1:0]  pop_data,
    ddo_out_if.source                  out_word,
    output ddo_pkg::ddo_back_status_t  status
);
    import ddo_pkg::*;

    localparam int NCH  = (TRAVEL_BITS + 15) / 16;
    localparam int PADW = NCH * 16;
    localparam int CHW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SW   = $clog2(CORDIC_STEPS);

    typedef enum logic [2:0] {B_IDLE, B_ROT, B_FIX, B_PROJ_X, B_PROJ_Y, B_WAIT} back_state_t;

    back_state_t                   state_reg;
    logic signed [TRAVEL_BITS-1:0] travel_reg;
    logic signed [TURN_BITS-1:0]   dth_reg;
    logic                          flip_reg;
    logic signed [TRIG_BITS-1:0]   x_reg;
    logic signed [TRIG_BITS-1:0]   y_reg;
    logic signed [ANGLE_BITS-1:0]  z_reg;
    logic [SW-1:0]                 cnt_reg;
    logic signed [TRIG_BITS-1:0]   cos_reg;
    logic signed [TRIG_BITS-1:0]   sin_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic [CHW-1:0]                idx_reg;
    logic [31:0]                   px_reg;
    logic [31:0]                   py_reg;
    logic [31:0]                   x_acc_reg;
    logic [31:0]                   y_acc_reg;
    logic [31:0]                   head_reg;
    logic [31:0]                   lin_reg;
    logic [31:0]                   ang_reg;
    logic                          us_zero_reg;
    logic                          tz_reg;
    logic                          out_valid_reg;

    logic signed [TRAVEL_BITS-1:0] q_travel;
    logic signed [TURN_BITS-1:0]   q_dth;
    logic [US_BITS-1:0]            q_us;
    logic signed [TURN_BITS-1:0]   q_half;
    logic [31:0]                   mid;
    logic [31:0]                   mid_flip;
    logic                          flip;
    logic [31:0]                   angle;
    logic                          pop;
    logic signed [TRIG_BITS-1:0]   dx;
    logic signed [TRIG_BITS-1:0]   dy;
    logic signed [ANGLE_BITS-1:0]  atan_s;
    logic signed [PADW-1:0]        pad;
    logic [15:0]                   chunk_raw;
    logic signed [16:0]            chunk_s;
    logic signed [TRIG_BITS-1:0]   trig;
    logic signed [50:0]            prod;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic signed [ACC_BITS-1:0]    acc_next;
    logic                          lin_done;
    logic                          ang_done;
    logic [31:0]                   lin_res;
    logic [31:0]                   ang_res;
    logic                          slot_free;
    logic                          load;

    assign q_travel = $signed(pop_data[WORD_BITS-1 -: TRAVEL_BITS]);
    assign q_dth    = $signed(pop_data[US_BITS +: TURN_BITS]);
    assign q_us     = pop_data[US_BITS-1:0];
    assign q_half   = q_dth >>> 1;
    assign mid      = head_reg + q_half[31:0];
    assign mid_flip = mid + 32'h4000_0000;
    assign flip     = mid_flip[31];
    assign angle    = flip ? mid + 32'h8000_0000 : mid;

    assign pop_ready = state_reg == B_IDLE;
    assign pop       = pop_valid && pop_ready;

    assign dx     = y_reg >>> cnt_reg;
    assign dy     = x_reg >>> cnt_reg;
    assign atan_s = $signed({1'b0, atan_turn(5'(cnt_reg))});

    assign pad       = travel_reg;
    assign chunk_raw = pad[16 * idx_reg +: 16];
    assign chunk_s   = (idx_reg == CHW'(NCH - 1)) ? $signed({chunk_raw[15], chunk_raw})
                                                  : $signed({1'b0, chunk_raw});
    assign trig      = (state_reg == B_PROJ_Y) ? sin_reg : cos_reg;
    assign prod      = chunk_s * trig;
    assign prod_ext  = prod;
    assign acc_next  = (acc_reg <<< 16) + prod_ext;

    assign slot_free = !out_valid_reg || out_word.ready;
    assign load      = (state_reg == B_WAIT) && lin_done && ang_done && slot_free;

    assign status.idle = state_reg == B_IDLE;
    assign status.load = load;

    assign out_word.valid            = out_valid_reg;
    assign out_word.pos_x            = $signed(x_acc_reg);
    assign out_word.pos_y            = $signed(y_acc_reg);
    assign out_word.heading          = head_reg;
    assign out_word.linear_velocity  = $signed(lin_reg);
    assign out_word.angular_velocity = $signed(ang_reg);
    assign out_word.time_zero        = tz_reg;

    ddo_rate_div #(.NUM_BITS(TRAVEL_BITS), .SHIFT(LIN_SHIFT)) u_lin_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pop),
        .num    (q_travel),
        .us     (q_us),
        .done   (lin_done),
        .result (lin_res)
    );

    ddo_rate_div #(.NUM_BITS(TURN_BITS), .SHIFT(ANG_SHIFT)) u_ang_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (pop),
        .num    (q_dth),
        .us     (q_us),
        .done   (ang_done),
        .result (ang_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            travel_reg    <= '0;
            dth_reg       <= '0;
            flip_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            z_reg         <= '0;
            cnt_reg       <= '0;
            cos_reg       <= '0;
            sin_reg       <= '0;
            acc_reg       <= '0;
            idx_reg       <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            head_reg      <= '0;
            lin_reg       <= '0;
            ang_reg       <= '0;
            us_zero_reg   <= 1'b0;
            tz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_word.ready && !load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        travel_reg  <= q_travel;
                        dth_reg     <= q_dth;
                        us_zero_reg <= q_us == '0;
                        flip_reg    <= flip;
                        x_reg       <= CORDIC_GAIN_Q30;
                        y_reg       <= '0;
                        z_reg       <= $signed(angle);
                        cnt_reg     <= '0;
                        state_reg   <= B_ROT;
                    end
                end
                B_ROT:
                begin
                    if (!z_reg[ANGLE_BITS-1])
                    begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_s;
                    end
                    else
                    begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_s;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == SW'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= B_FIX;
                    end
                end
                B_FIX:
                begin
                    cos_reg   <= flip_reg ? -x_reg : x_reg;
                    sin_reg   <= flip_reg ? -y_reg : y_reg;
                    acc_reg   <= '0;
                    idx_reg   <= CHW'(NCH - 1);
                    state_reg <= B_PROJ_X;
                end
                B_PROJ_X:
                begin
                    if (idx_reg == '0)
                    begin
                        px_reg    <= acc_next[70:39];
                        acc_reg   <= '0;
                        idx_reg   <= CHW'(NCH - 1);
                        state_reg <= B_PROJ_Y;
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                B_PROJ_Y:
                begin
                    if (idx_reg == '0)
                    begin
                        py_reg    <= acc_next[70:39];
                        state_reg <= B_WAIT;
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                B_WAIT:
                begin
                    if (load)
                    begin
                        x_acc_reg     <= x_acc_reg + px_reg;
                        y_acc_reg     <= y_acc_reg + py_reg;
                        head_reg      <= head_reg + dth_reg[31:0];
                        lin_reg       <= lin_res;
                        ang_reg       <= ang_res;
                        tz_reg        <= us_zero_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/differential_drive_odometry.sv -----
// Differential-drive wheel odometry: top level with configuration registers.
//
// Input channel odo_in takes one word per encoder sample: raw left and right
// counts and the microseconds since the previous sample. Output channel
// odo_out returns one word per sample: x, y, heading, linear and angular
// velocity, and a flag for a zero elapsed time.
// The result word passes the front stage registers and the queue, then the
// back end, where CORDIC_STEPS rotation steps and two projections over
// ceil((COUNT_BITS + 26) / 16) 16-bit chunks of the travel each run alongside
// two serial velocity dividers before the output load. The back end takes
// the next word from the queue only after the previous result is loaded.
// The front keeps taking samples into a two-word queue while the back works
// and while a finished result waits in the output register; a stalled
// receiver backs up the back end, then the queue, then odo_in.ready.
// Reset clears the pose, the previous counts and all valid flags and loads
// the register defaults. Registers are written through cfg_we, cfg_index
// and cfg_data by the user, only while the block is idle (not enforced).
`default_nettype none
`include "differential_drive_odometry_macros.svh"
module differential_drive_odometry #(
    parameter int COUNT_BITS = ddo_pkg::COUNT_BITS_DEFAULT,
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    ddo_in_if.sink                                   odo_in,
    ddo_out_if.source                                odo_out,
    input  wire logic                                cfg_we,
    input  wire logic [ddo_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [ddo_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import ddo_pkg::*;

    localparam int WORD_BITS = (COUNT_BITS + 26) + (COUNT_BITS + 30) + US_BITS;

    ddo_cfg_t             cfg_reg;
    logic                 q_push_valid;
    logic                 q_push_ready;
    logic [WORD_BITS-1:0] q_push_data;
    logic                 q_pop_valid;
    logic                 q_pop_ready;
    logic [WORD_BITS-1:0] q_pop_data;
    ddo_back_status_t     back_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.distance_per_count        <= DISTANCE_RESET;
            cfg_reg.turn_per_count_difference <= TURN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISTANCE: cfg_reg.distance_per_count <= cfg_data[DIST_BITS-1:0];
                CFG_TURN:     cfg_reg.turn_per_count_difference <= cfg_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    ddo_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_word    (odo_in),
        .cfg        (cfg_reg),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data)
    );

    ddo_queue #(.WIDTH(WORD_BITS)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    ddo_back #(.COUNT_BITS(COUNT_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_pop_valid),
        .pop_ready (q_pop_ready),
        .pop_data  (q_pop_data),
        .out_word  (odo_out),
        .status    (back_status)
    );

    `DDO_ASSERT_SAME(a_load_slot_free, clk, rst_n, back_status.load, !odo_out.valid || odo_out.ready)
    `DDO_ASSERT_NEXT(a_load_shows_word, clk, rst_n, back_status.load, odo_out.valid)
    `DDO_ASSERT_SAME(a_pop_when_idle, clk, rst_n, q_pop_valid && q_pop_ready, back_status.idle)
endmodule
`default_nettype wire

// ----- tb/sv/differential_drive_odometry_tb.sv -----
// Self-checking testbench for the differential-drive odometry block.
`default_nettype none
module differential_drive_odometry_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddo_pkg::*;

    typedef struct {
        logic [15:0] left_count;
        logic [15:0] right_count;
        logic [19:0] elapsed_us;
    } sample_t;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [31:0] heading;
        logic signed [31:0] linear_velocity;
        logic signed [31:0] angular_velocity;
        logic               time_zero;
    } pose_t;

    localparam longint ATAN_TURNS [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    ddo_in_if in_ch ();
    ddo_out_if out_ch ();

    differential_drive_odometry dut (
        .clk(clk),
        .rst_n(rst_n),
        .odo_in(in_ch),
        .odo_out(out_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    sample_t pending_samples[$];
    pose_t expected_poses[$];
    sample_t tx_sample;
    int mismatches = 0;
    bit calm = 1'b0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_cnt = 0;
    int tx_gap = 0;
    int rx_stall = 0;

    logic [23:0] dist_reg;
    logic [27:0] turn_reg;
    logic [15:0] last_left, last_right;
    logic [31:0] x_acc, y_acc, heading_acc;
    logic [15:0] gen_left = '0, gen_right = '0;

    function automatic longint wrap_delta(logic [15:0] cur, logic [15:0] prev);
        logic signed [15:0] d;
        d = cur - prev;
        return longint'(d);
    endfunction

    function automatic void rotate(logic [31:0] angle, output longint c,
                                   output longint s);
        logic [31:0] a;
        logic flip;
        longint x, y, z, dx, dy;
        a = angle + 32'h4000_0000;
        flip = a[31];
        a = flip ? angle + 32'h8000_0000 : angle;
        x = 652032874;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < CORDIC_STEPS_DEFAULT; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ATAN_TURNS[i];
            end
            else
            begin
                x += dx; y -= dy; z += ATAN_TURNS[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [31:0] project(longint a, longint c);
        longint h, m, l, inner, sum;
        h = a >>> 40;
        m = (a >> 20) & 64'hFFFFF;
        l = a & 64'hFFFFF;
        inner = (m * c + ((l * c) >>> 20)) >>> 19;
        sum = 2 * h * c + inner;
        return sum[31:0];
    endfunction

    function automatic logic [31:0] speed(longint num, logic [19:0] us, int shift);
        longint unsigned mag, q;
        if (us == 0)
            return 32'd0;
        mag = (num < 0) ? longint'(-num) : num;
        if (mag >= (64'd1 << 43))
            q = 64'd1 << 40;
        else
            q = (mag * 64'd1000000) / (longint'(us) << shift);
        if (num < 0)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return 32'd0 - q[31:0];
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic pose_t advance_pose(sample_t smp);
        longint dl, dr, travel, dth, c, s;
        logic [31:0] mid;
        pose_t p;
        dl = wrap_delta(smp.left_count, last_left);
        dr = wrap_delta(smp.right_count, last_right);
        travel = (dl + dr) * longint'(dist_reg);
        dth = (dr - dl) * longint'(turn_reg);
        mid = heading_acc + 32'(dth >>> 1);
        rotate(mid, c, s);
        x_acc += project(travel, c);
        y_acc += project(travel, s);
        heading_acc += 32'(dth);
        last_left = smp.left_count;
        last_right = smp.right_count;
        p.pos_x = x_acc;
        p.pos_y = y_acc;
        p.heading = heading_acc;
        p.linear_velocity = speed(travel, smp.elapsed_us, LIN_SHIFT);
        p.angular_velocity = speed(dth, smp.elapsed_us, ANG_SHIFT);
        p.time_zero = (smp.elapsed_us == 0);
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            tx_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_poses.push_back(advance_pose(tx_sample));
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0 && !calm && $urandom_range(0, 9) == 0)
                begin
                    tx_gap <= $urandom_range(0, 10);
                    in_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    tx_sample = pending_samples.pop_front();
                    in_ch.left_count <= tx_sample.left_count;
                    in_ch.right_count <= tx_sample.right_count;
                    in_ch.elapsed_us <= tx_sample.elapsed_us;
                    in_ch.valid <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_poses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pose word x=%0d y=%0d", out_ch.pos_x, out_ch.pos_y);
                end
                else
                begin
                    pose_t e;
                    e = expected_poses.pop_front();
                    if (out_ch.pos_x !== e.pos_x || out_ch.pos_y !== e.pos_y
                        || out_ch.heading !== e.heading
                        || out_ch.linear_velocity !== e.linear_velocity
                        || out_ch.angular_velocity !== e.angular_velocity
                        || out_ch.time_zero !== e.time_zero)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch exp x=%0d y=%0d h=%0d v=%0d w=%0d tz=%0b",
                                e.pos_x, e.pos_y, e.heading, e.linear_velocity,
                                e.angular_velocity, e.time_zero);
                            $display("         act x=%0d y=%0d h=%0d v=%0d w=%0d tz=%0b",
                                out_ch.pos_x, out_ch.pos_y, out_ch.heading,
                                out_ch.linear_velocity, out_ch.angular_velocity,
                                out_ch.time_zero);
                        end
                    end
                end
            end
            if (hold_seen != hold_token)
            begin
                hold_seen <= hold_token;
                hold_cnt <= 600;
                out_ch.ready <= 1'b0;
            end
            else if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                out_ch.ready <= 1'b0;
            end
            else if (calm)
                out_ch.ready <= 1'b1;
            else if (rx_stall > 0)
            begin
                rx_stall <= rx_stall - 1;
                out_ch.ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                rx_stall <= $urandom_range(0, 10);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(ddo_cfg_index_t idx, logic [27:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DISTANCE)
            dist_reg = val[23:0];
        else
            turn_reg = val;
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || expected_poses.size() != 0 || in_ch.valid)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic push(logic [15:0] l, logic [15:0] r, logic [19:0] us);
        sample_t smp;
        smp.left_count = l;
        smp.right_count = r;
        smp.elapsed_us = us;
        gen_left = l;
        gen_right = r;
        pending_samples.push_back(smp);
    endtask

    task automatic push_random();
        int sel;
        logic [19:0] us;
        sel = $urandom_range(0, 19);
        us = (sel == 0) ? 20'd0 : (sel == 1) ? 20'd1000000
                                             : 20'($urandom_range(1, 1000000));
        if (sel < 16)
            push(gen_left + 16'($signed($urandom_range(0, 400)) - 200),
                 gen_right + 16'($signed($urandom_range(0, 400)) - 200), us);
        else if (sel < 18)
            push(gen_left + 16'($signed($urandom_range(0, 8000)) - 4000),
                 gen_right - 16'($signed($urandom_range(0, 8000)) - 4000), us);
        else
            push(16'($urandom), 16'($urandom), us);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            push_random();
            while (pending_samples.size() > 8)
                @(posedge clk);
        end
        drain();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.left_count = '0;
        in_ch.right_count = '0;
        in_ch.elapsed_us = '0;
        out_ch.ready = 1'b0;
        dist_reg = DISTANCE_RESET;
        turn_reg = TURN_RESET;
        last_left = '0;
        last_right = '0;
        x_acc = '0;
        y_acc = '0;
        heading_acc = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        push(16'd0, 16'd0, 20'd0);
        push(16'd100, 16'd100, 20'd1);
        push(16'd50, 16'd150, 20'd1000000);
        push(16'hFFFF, 16'h0000, 20'd20000);
        push(16'h7FFF, 16'h8000, 20'd1);
        push(16'hFFFF, 16'h0000, 20'd0);
        push(16'h7FFF, 16'h7FFF, 20'd1);
        push(16'hFFFF, 16'hFFFF, 20'd1000000);
        push(16'h0100, 16'h0080, 20'd50000);
        push(16'h0300, 16'h0200, 20'd999999);
        push(16'h0000, 16'hFFFF, 20'd524288);
        push(16'h8000, 16'h8000, 20'd1);
        drain();

        write_reg(CFG_DISTANCE, 28'hFFFFFF);
        write_reg(CFG_TURN, 28'hFFFFFFF);
        push(gen_left + 16'd32767, gen_right - 16'd32768, 20'd1);
        push(gen_left - 16'd32768, gen_right + 16'd32767, 20'd1);
        push(gen_left + 16'd5, gen_right + 16'd9, 20'd0);
        random_phase(120);

        write_reg(CFG_DISTANCE, 28'd1);
        write_reg(CFG_TURN, 28'd1);
        random_phase(100);

        write_reg(CFG_DISTANCE, 28'd0);
        write_reg(CFG_TURN, 28'd0);
        random_phase(20);

        write_reg(CFG_DISTANCE, 28'(DISTANCE_RESET));
        write_reg(CFG_TURN, TURN_RESET);
        hold_token++;
        for (int i = 0; i < 20; i++)
            push_random();
        random_phase(200);

        for (int k = 0; k < 3; k++)
        begin
            write_reg(CFG_DISTANCE, 28'($urandom_range(1, 24'hFFFFFF)));
            write_reg(CFG_TURN, 28'($urandom_range(1, 28'hFFFFFFF)));
            random_phase(150);
        end

        write_reg(CFG_TURN, 28'd40000000);
        calm = 1'b1;
        random_phase(110);

        if (mismatches == 0)
            $display("differential_drive_odometry test passed");
        else
            $display("differential_drive_odometry test failed");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("differential_drive_odometry test failed");
        $finish;
    end
endmodule
`default_nettype wire
